>>> hdl/tls_server_hello_key_share_parser_unit_defines.svh
// Assertion macros shared by the checker of the ServerHello key share parser.
// No dependencies; taken in by `include.
`ifndef TLS_SERVER_HELLO_KEY_SHARE_PARSER_UNIT_DEFINES_SVH
`define TLS_SERVER_HELLO_KEY_SHARE_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define TLSSHP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TLSSHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/tlsshp_pkg.sv
// Types and constants for the ServerHello key share parser.
// No dependencies; imported by every module of the block.
package tlsshp_pkg;

   localparam int KEY_BYTES    = 32;
   localparam int KEY_IDX_BITS = $clog2(KEY_BYTES);
   localparam int LEN_BITS     = 16;

   localparam logic [7:0]          MSG_SERVER_HELLO = 8'd2;
   localparam logic [LEN_BITS-1:0] MIN_MSG_LEN      = 16'd40;
   localparam logic [LEN_BITS-1:0] HEADER_LAST_POS  = 16'd37;
   localparam logic [15:0]         EXT_KEY_SHARE    = 16'h0033;
   localparam logic [15:0]         GROUP_X25519     = 16'h001d;
   localparam logic [15:0]         MIN_SHARE_LEN    = 16'd36;
   localparam logic [15:0]         SHARE_KEY_LEN    = 16'd32;
   localparam logic [15:0]         SHARE_LAST_OFF   = 16'd35;
   localparam logic [15:0]         SHARE_KEY_OFF    = 16'd4;

   typedef enum logic [11:0] {
      PH_HEADER     = 12'b0000_0000_0001,
      PH_SID_LEN    = 12'b0000_0000_0010,
      PH_SID_SKIP   = 12'b0000_0000_0100,
      PH_CIPH_HI    = 12'b0000_0000_1000,
      PH_CIPH_LO    = 12'b0000_0001_0000,
      PH_COMP       = 12'b0000_0010_0000,
      PH_EXT_TOT_HI = 12'b0000_0100_0000,
      PH_EXT_TOT_LO = 12'b0000_1000_0000,
      PH_EXT_HDR    = 12'b0001_0000_0000,
      PH_EXT_BODY   = 12'b0010_0000_0000,
      PH_DONE       = 12'b0100_0000_0000,
      PH_STOP       = 12'b1000_0000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic [LEN_BITS-1:0] total_length;
      logic                end_of_message;
   } req_type;

   typedef struct packed {
      logic                    status;
      logic [15:0]             cipher_suite;
      logic [7:0]              key_byte;
      logic [KEY_IDX_BITS-1:0] key_index;
      logic                    last_result;
   } rsp_type;

   // candidate key write and commit, parser to key store
   typedef struct packed {
      logic                    wr_en;
      logic [KEY_IDX_BITS-1:0] wr_index;
      logic [7:0]              wr_data;
      logic                    commit;
   } key_wr_type;

   // end-of-message verdict, parser to result emitter
   typedef struct packed {
      logic        start;
      logic        fail;
      logic [15:0] cipher;
   } job_type;

endpackage

>>> hdl/tls_server_hello_key_share_parser_unit.sv
// ServerHello key share parser, top level.
// Input channel req_: one message byte per transaction, with the total message
// length and an end-of-message mark. Result channel rsp_: on the marked byte,
// either one failure result (status 1) or 32 key-byte results (status 0) in
// key_index order, all carrying the cipher suite; last_result marks the final one.
// Throughput: one byte per cycle while req_ready is high. Latency: the first result is valid
// in the cycle after the marked byte is taken; a key burst then runs at one
// result per cycle while rsp_ready is high.
// The result register decouples the channels: bytes keep flowing during a burst.
// req_ready drops only for a byte that would start a new result run, or would
// commit a new key, before the current run has drained (the key banks and the
// result register are shared by consecutive messages).
// Stalls on rsp_ready hold the current result unchanged.
// Reset (synchronous) returns the parser to the header phase and empties the
// result register; the key banks need no clearing.
// Depends on tlsshp_pkg, tlsshp_parser, tlsshp_key_store, tlsshp_emitter.
module tls_server_hello_key_share_parser_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tlsshp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tlsshp_pkg::rsp_type rsp_data
);
   import tlsshp_pkg::*;

   logic                    req_fire;
   logic                    needs_emitter;
   logic                    emit_free;
   key_wr_type              key_wr;
   job_type                 job;
   logic [KEY_IDX_BITS-1:0] key_index;
   logic [7:0]              key_data;

   assign req_ready = emit_free || !needs_emitter;
   assign req_fire  = req_valid && req_ready;

   tlsshp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .req_fire      (req_fire),
      .needs_emitter (needs_emitter),
      .key_wr        (key_wr),
      .job           (job)
   );

   tlsshp_key_store u_key_store (
      .clock    (clock),
      .reset    (reset),
      .key_wr   (key_wr),
      .rd_index (key_index),
      .rd_data  (key_data)
   );

   tlsshp_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .key_data  (key_data),
      .key_index (key_index),
      .emit_free (emit_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hdl/tlsshp_parser.sv
// Byte-wise ServerHello parser: phase register, field captures, verdict.
// Depends on tlsshp_pkg.
module tlsshp_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  tlsshp_pkg::req_type    req_data,
   input  logic                 req_fire,
   output logic                 needs_emitter,
   output tlsshp_pkg::key_wr_type key_wr,
   output tlsshp_pkg::job_type    job
);
   import tlsshp_pkg::*;

   logic [LEN_BITS-1:0] pos_ff, pos_in;
   phase_type           phase_ff, phase_in;
   logic [7:0]          sid_ff, sid_in;
   logic [15:0]         cipher_ff, cipher_in;
   logic [LEN_BITS:0]   ext_end_ff, ext_end_in;
   logic [15:0]         ext_type_ff, ext_type_in;
   logic [15:0]         ext_len_ff, ext_len_in;
   logic [15:0]         ext_off_ff, ext_off_in;
   logic [15:0]         grp_ff, grp_in;
   logic [15:0]         shlen_ff, shlen_in;
   logic                found_ff, found_in;
   logic                failed_ff, failed_in;

   logic [7:0]          b;
   logic [LEN_BITS-1:0] len;
   logic [LEN_BITS:0]   ext_end_sum;
   logic [15:0]         ext_len_full;
   logic [15:0]         ext_off_inc;
   logic [LEN_BITS+1:0] hdr_need;
   logic [LEN_BITS+1:0] ext_need;
   logic                wr_en, commit;
   logic [KEY_IDX_BITS-1:0] wr_index;
   logic                ciph_ok;

   assign b   = req_data.data_byte;
   assign len = req_data.total_length;

   assign ext_end_sum  = {1'b0, pos_ff} + 17'd1 + {1'b0, ext_end_ff[15:8], b};
   assign ext_len_full = {ext_len_ff[15:8], b};
   assign ext_off_inc  = ext_off_ff + 16'd1;
   assign hdr_need     = {2'b00, pos_ff} + 18'd4;
   assign ext_need     = {2'b00, pos_ff} + 18'd1 + {2'b00, ext_len_full};

   always_comb begin
      pos_in      = (pos_ff != {LEN_BITS{1'b1}}) ? pos_ff + 16'd1 : pos_ff;
      phase_in    = phase_ff;
      sid_in      = sid_ff;
      cipher_in   = cipher_ff;
      ext_end_in  = ext_end_ff;
      ext_type_in = ext_type_ff;
      ext_len_in  = ext_len_ff;
      ext_off_in  = ext_off_ff;
      grp_in      = grp_ff;
      shlen_in    = shlen_ff;
      found_in    = found_ff;
      failed_in   = failed_ff;
      wr_en       = 1'b0;
      wr_index    = ext_off_ff[KEY_IDX_BITS-1:0] - SHARE_KEY_OFF[KEY_IDX_BITS-1:0];
      commit      = 1'b0;
      if (pos_ff < len) begin
         case (phase_ff)
            PH_HEADER: begin
               if (pos_ff == '0 && b != MSG_SERVER_HELLO) begin
                  failed_in = 1'b1;
                  phase_in  = PH_STOP;
               end else if (pos_ff >= HEADER_LAST_POS) begin
                  phase_in = PH_SID_LEN;
               end
            end
            PH_SID_LEN: begin
               sid_in   = b;
               phase_in = (b == 8'd0) ? PH_CIPH_HI : PH_SID_SKIP;
            end
            PH_SID_SKIP: begin
               sid_in = sid_ff - 8'd1;
               if (sid_ff == 8'd1) phase_in = PH_CIPH_HI;
            end
            PH_CIPH_HI: begin
               cipher_in = {b, 8'd0};
               phase_in  = PH_CIPH_LO;
            end
            PH_CIPH_LO: begin
               cipher_in = {cipher_ff[15:8], b};
               phase_in  = PH_COMP;
            end
            PH_COMP: begin
               phase_in = PH_EXT_TOT_HI;
            end
            PH_EXT_TOT_HI: begin
               ext_end_in = {1'b0, b, 8'd0};
               phase_in   = PH_EXT_TOT_LO;
            end
            PH_EXT_TOT_LO: begin
               // extensions block end, clipped to the message length
               ext_end_in = (ext_end_sum > {1'b0, len}) ? {1'b0, len} : ext_end_sum;
               ext_off_in = 16'd0;
               phase_in   = PH_EXT_HDR;
            end
            PH_EXT_HDR: begin
               if (ext_off_ff == 16'd0) begin
                  if (hdr_need > {1'b0, ext_end_ff}) begin
                     phase_in = PH_DONE;
                  end else begin
                     ext_type_in = {b, 8'd0};
                     ext_off_in  = ext_off_inc;
                  end
               end else if (ext_off_ff == 16'd1) begin
                  ext_type_in = {ext_type_ff[15:8], b};
                  ext_off_in  = ext_off_inc;
               end else if (ext_off_ff == 16'd2) begin
                  ext_len_in = {b, 8'd0};
                  ext_off_in = ext_off_inc;
               end else begin
                  ext_len_in = ext_len_full;
                  ext_off_in = 16'd0;
                  if (ext_need > {1'b0, ext_end_ff}) begin
                     phase_in = PH_DONE;
                  end else if (ext_len_full != 16'd0) begin
                     phase_in = PH_EXT_BODY;
                  end
               end
            end
            PH_EXT_BODY: begin
               if (ext_type_ff == EXT_KEY_SHARE && ext_len_ff >= MIN_SHARE_LEN) begin
                  if (ext_off_ff == 16'd0) begin
                     grp_in = {b, 8'd0};
                  end else if (ext_off_ff == 16'd1) begin
                     grp_in = {grp_ff[15:8], b};
                  end else if (ext_off_ff == 16'd2) begin
                     shlen_in = {b, 8'd0};
                  end else if (ext_off_ff == 16'd3) begin
                     shlen_in = {shlen_ff[15:8], b};
                  end else if (ext_off_ff < MIN_SHARE_LEN) begin
                     wr_en = 1'b1;
                     if (ext_off_ff == SHARE_LAST_OFF && grp_ff == GROUP_X25519 &&
                         shlen_ff == SHARE_KEY_LEN) begin
                        commit   = 1'b1;
                        found_in = 1'b1;
                     end
                  end
               end
               if (ext_off_inc >= ext_len_ff) begin
                  ext_off_in = 16'd0;
                  phase_in   = PH_EXT_HDR;
               end else begin
                  ext_off_in = ext_off_inc;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // a commit flips the key banks, so it must wait for a free emitter too
   assign needs_emitter = req_data.end_of_message || commit;

   assign key_wr.wr_en    = req_fire && wr_en;
   assign key_wr.wr_index = wr_index;
   assign key_wr.wr_data  = b;
   assign key_wr.commit   = req_fire && commit;

   assign ciph_ok = !failed_in && len >= MIN_MSG_LEN &&
                    (phase_in == PH_EXT_TOT_HI || phase_in == PH_EXT_TOT_LO ||
                     phase_in == PH_EXT_HDR || phase_in == PH_EXT_BODY ||
                     phase_in == PH_DONE);

   assign job.start  = req_fire && req_data.end_of_message;
   assign job.fail   = failed_in || len < MIN_MSG_LEN || pos_in < len || !found_in;
   assign job.cipher = ciph_ok ? cipher_in : 16'd0;

   always_ff @(posedge clock) begin
      if (reset || (req_fire && req_data.end_of_message)) begin
         pos_ff      <= '0;
         phase_ff    <= PH_HEADER;
         sid_ff      <= '0;
         cipher_ff   <= '0;
         ext_end_ff  <= '0;
         ext_type_ff <= '0;
         ext_len_ff  <= '0;
         ext_off_ff  <= '0;
         grp_ff      <= '0;
         shlen_ff    <= '0;
         found_ff    <= 1'b0;
         failed_ff   <= 1'b0;
      end else if (req_fire) begin
         pos_ff      <= pos_in;
         phase_ff    <= phase_in;
         sid_ff      <= sid_in;
         cipher_ff   <= cipher_in;
         ext_end_ff  <= ext_end_in;
         ext_type_ff <= ext_type_in;
         ext_len_ff  <= ext_len_in;
         ext_off_ff  <= ext_off_in;
         grp_ff      <= grp_in;
         shlen_ff    <= shlen_in;
         found_ff    <= found_in;
         failed_ff   <= failed_in;
      end
   end

endmodule

>>> hdl/tlsshp_key_store.sv
// Two key banks: one fills with the candidate key, the other holds the found key.
// A commit swaps their roles. Depends on tlsshp_pkg.
module tlsshp_key_store (
   input  logic                              clock,
   input  logic                              reset,
   input  tlsshp_pkg::key_wr_type              key_wr,
   input  logic [tlsshp_pkg::KEY_IDX_BITS-1:0] rd_index,
   output logic [7:0]                        rd_data
);
   import tlsshp_pkg::*;

   logic [7:0] bank0_ff [KEY_BYTES];
   logic [7:0] bank1_ff [KEY_BYTES];
   logic       sel_ff, sel_in;

   assign sel_in = key_wr.commit ? !sel_ff : sel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
      end
   end

   // candidate bank is the one not selected
   always_ff @(posedge clock) begin
      if (key_wr.wr_en && sel_ff) begin
         bank0_ff[key_wr.wr_index] <= key_wr.wr_data;
      end
      if (key_wr.wr_en && !sel_ff) begin
         bank1_ff[key_wr.wr_index] <= key_wr.wr_data;
      end
   end

   assign rd_data = sel_ff ? bank1_ff[rd_index] : bank0_ff[rd_index];

endmodule

>>> hdl/tlsshp_emitter.sv
// Result register and beat counter: one failure result or a burst of key bytes.
// Depends on tlsshp_pkg.
module tlsshp_emitter (
   input  logic                              clock,
   input  logic                              reset,
   input  tlsshp_pkg::job_type                 job,
   input  logic [7:0]                        key_data,
   output logic [tlsshp_pkg::KEY_IDX_BITS-1:0] key_index,
   output logic                              emit_free,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tlsshp_pkg::rsp_type                 rsp_data
);
   import tlsshp_pkg::*;

   localparam logic [KEY_IDX_BITS-1:0] LAST_IDX = KEY_IDX_BITS'(KEY_BYTES - 1);

   logic                    valid_ff;
   logic                    status_ff;
   logic [15:0]             cipher_ff;
   logic [KEY_IDX_BITS-1:0] index_ff;
   logic                    last;

   assign last      = status_ff || index_ff == LAST_IDX;
   assign emit_free = !valid_ff || (rsp_ready && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         index_ff <= '0;
      end else if (job.start) begin
         valid_ff <= 1'b1;
         index_ff <= '0;
      end else if (valid_ff && rsp_ready) begin
         if (last) begin
            valid_ff <= 1'b0;
         end else begin
            index_ff <= index_ff + KEY_IDX_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job.start) begin
         status_ff <= job.fail;
         cipher_ff <= job.cipher;
      end
   end

   assign key_index             = index_ff;
   assign rsp_valid             = valid_ff;
   assign rsp_data.status       = status_ff;
   assign rsp_data.cipher_suite = cipher_ff;
   assign rsp_data.key_byte     = status_ff ? 8'd0 : key_data;
   assign rsp_data.key_index    = status_ff ? '0 : index_ff;
   assign rsp_data.last_result  = last;

endmodule

>>> hdl/tlsshp_checker.sv
// Port-level checks for the ServerHello key share parser, bound to the top level.
// Depends on tlsshp_pkg and tls_server_hello_key_share_parser_unit_defines.svh.
`include "tls_server_hello_key_share_parser_unit_defines.svh"

module tlsshp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input tlsshp_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input tlsshp_pkg::rsp_type rsp_data
);
   import tlsshp_pkg::*;

   // stalled result holds
   `TLSSHP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   // a key burst runs without gaps, index counting up
   `TLSSHP_ASSERT_NEXT(a_burst_step, clock, reset, rsp_valid && rsp_ready && !rsp_data.last_result, rsp_valid && rsp_data.key_index == $past(rsp_data.key_index) + KEY_IDX_BITS'(1), "key burst broke")

   // failure is a single result with zero key fields
   `TLSSHP_ASSERT_NOW(a_fail_single, clock, reset, rsp_valid && rsp_data.status, rsp_data.last_result && rsp_data.key_index == '0 && rsp_data.key_byte == 8'd0, "malformed failure result")

   // end of message always produces a result next cycle
   `TLSSHP_ASSERT_NEXT(a_end_result, clock, reset, req_valid && req_ready && req_data.end_of_message, rsp_valid, "no result after end of message")

endmodule

bind tls_server_hello_key_share_parser_unit tlsshp_checker u_checker (.*);

>>> dv/tlsshp_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the ServerHello key share parser: follows both channels, predicts
// the failure or key-byte results of every message and compares them in order.
// Depends on tlsshp_pkg; instantiated beside the block by tb.
module tlsshp_result_checker
   import tlsshp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      results_pending
);

   localparam int unsigned POS_MAX    = (1 << LEN_BITS) - 1;
   localparam int          SHOW_LINES = 40;

   rsp_type     key_results_q[$];
   int unsigned msg_pos;
   phase_type   phase;
   logic [7:0]  sid_left;
   logic [15:0] suite;
   int unsigned ext_limit;
   logic [15:0] ext_kind;
   logic [15:0] ext_len;
   int unsigned ext_off;
   logic [15:0] share_grp;
   logic [15:0] share_len;
   logic [7:0]  cand_key[KEY_BYTES];
   logic [7:0]  kept_key[KEY_BYTES];
   logic        key_kept;
   logic        hello_bad;

   task automatic note_mismatch(input string msg);
      error_count++;
      if (error_count <= SHOW_LINES) $display("%0t mismatch: %s", $time, msg);
   endtask

   // key stores are left alone: they are only read after a full key was kept
   task automatic clear_parse();
      msg_pos   = 0;
      phase     = PH_HEADER;
      sid_left  = '0;
      suite     = '0;
      ext_limit = 0;
      ext_kind  = '0;
      ext_len   = '0;
      ext_off   = 0;
      share_grp = '0;
      share_len = '0;
      key_kept  = 1'b0;
      hello_bad = 1'b0;
   endtask

   task automatic parse_hello_byte(input int unsigned p, input logic [7:0] b,
                                   input int unsigned len);
      int unsigned lim;
      case (phase)
         PH_HEADER: begin
            if (p == 0 && b != MSG_SERVER_HELLO) begin
               hello_bad = 1'b1;
               phase     = PH_STOP;
            end else if (p >= HEADER_LAST_POS) begin
               phase = PH_SID_LEN;
            end
         end
         PH_SID_LEN: begin
            sid_left = b;
            if (b == 8'd0) phase = PH_CIPH_HI;
            else phase = PH_SID_SKIP;
         end
         PH_SID_SKIP: begin
            sid_left = sid_left - 8'd1;
            if (sid_left == 8'd0) phase = PH_CIPH_HI;
         end
         PH_CIPH_HI: begin
            suite = {b, 8'h00};
            phase = PH_CIPH_LO;
         end
         PH_CIPH_LO: begin
            suite[7:0] = b;
            phase      = PH_COMP;
         end
         PH_COMP: phase = PH_EXT_TOT_HI;
         PH_EXT_TOT_HI: begin
            ext_limit = {b, 8'h00};
            phase     = PH_EXT_TOT_LO;
         end
         PH_EXT_TOT_LO: begin
            // the extension block never reaches past the message itself
            lim       = p + 1 + (ext_limit | b);
            ext_limit = (lim > len) ? len : lim;
            ext_off   = 0;
            phase     = PH_EXT_HDR;
         end
         PH_EXT_HDR: begin
            case (ext_off)
               0: begin
                  if (p + 4 > ext_limit) phase = PH_DONE;
                  else begin
                     ext_kind = {b, 8'h00};
                     ext_off  = 1;
                  end
               end
               1: begin
                  ext_kind[7:0] = b;
                  ext_off       = 2;
               end
               2: begin
                  ext_len = {b, 8'h00};
                  ext_off = 3;
               end
               default: begin
                  ext_len[7:0] = b;
                  ext_off      = 0;
                  if (p + 1 + ext_len > ext_limit) phase = PH_DONE;
                  else if (ext_len != 16'd0) phase = PH_EXT_BODY;
               end
            endcase
         end
         PH_EXT_BODY: begin
            if (ext_kind == EXT_KEY_SHARE && ext_len >= MIN_SHARE_LEN) begin
               if (ext_off == 0) share_grp = {b, 8'h00};
               else if (ext_off == 1) share_grp[7:0] = b;
               else if (ext_off == 2) share_len = {b, 8'h00};
               else if (ext_off == 3) share_len[7:0] = b;
               else if (ext_off < MIN_SHARE_LEN) begin
                  cand_key[ext_off - SHARE_KEY_OFF] = b;
                  // a complete x25519 share replaces any earlier one
                  if (ext_off == SHARE_LAST_OFF && share_grp == GROUP_X25519 &&
                      share_len == SHARE_KEY_LEN) begin
                     kept_key = cand_key;
                     key_kept = 1'b1;
                  end
               end
            end
            ext_off++;
            if (ext_off >= ext_len) begin
               ext_off = 0;
               phase   = PH_EXT_HDR;
            end
         end
         default: ;
      endcase
   endtask

   task automatic take_hello_byte(input req_type t);
      int unsigned len;
      int unsigned seen;
      logic        suite_ok;
      logic        no_key;
      rsp_type     r;
      int          i;
      len = t.total_length;
      if (msg_pos < len) parse_hello_byte(msg_pos, t.data_byte, len);
      if (msg_pos < POS_MAX) msg_pos++;
      seen = msg_pos;
      if (t.end_of_message) begin
         suite_ok = !hello_bad && len >= MIN_MSG_LEN &&
                    (phase == PH_EXT_TOT_HI || phase == PH_EXT_TOT_LO ||
                     phase == PH_EXT_HDR || phase == PH_EXT_BODY || phase == PH_DONE);
         no_key   = hello_bad || len < MIN_MSG_LEN || seen < len || !key_kept;
         r.cipher_suite = suite_ok ? suite : 16'h0000;
         if (no_key) begin
            r.status      = 1'b1;
            r.key_byte    = '0;
            r.key_index   = '0;
            r.last_result = 1'b1;
            key_results_q.push_back(r);
         end else begin
            for (i = 0; i < KEY_BYTES; i++) begin
               r.status      = 1'b0;
               r.key_byte    = kept_key[i];
               r.key_index   = KEY_IDX_BITS'(i);
               r.last_result = (i == KEY_BYTES - 1);
               key_results_q.push_back(r);
            end
         end
         clear_parse();
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (key_results_q.size() == 0) begin
         note_mismatch($sformatf("result with nothing expected: %h", got));
      end else begin
         want = key_results_q.pop_front();
         if (got.status != want.status)
            note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.cipher_suite != want.cipher_suite)
            note_mismatch($sformatf("cipher_suite %h, expected %h",
                                    got.cipher_suite, want.cipher_suite));
         if (got.key_byte != want.key_byte)
            note_mismatch($sformatf("key_byte[%0d] %h, expected %h",
                                    want.key_index, got.key_byte, want.key_byte));
         if (got.key_index != want.key_index)
            note_mismatch($sformatf("key_index %0d, expected %0d",
                                    got.key_index, want.key_index));
         if (got.last_result != want.last_result)
            note_mismatch($sformatf("last_result %0d, expected %0d",
                                    got.last_result, want.last_result));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
         key_results_q.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_result(rsp_data);
         if (req_valid && req_ready) take_hello_byte(req_data);
      end
      results_pending = key_results_q.size();
   end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the ServerHello key share parser: builds handshake messages, feeds
// them byte by byte, paces the result side and gives the verdict.
// Depends on tlsshp_pkg, tls_server_hello_key_share_parser_unit and tlsshp_result_checker.
module tb;
   import tlsshp_pkg::*;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = 40;
   localparam int PER_PHASE   = 28;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   int          error_count;
   int          results_pending;
   int          send_idle_pct  = 0;
   int          recv_stall_pct = 0;
   logic        hold_toggle    = 1'b0;
   logic [7:0]  hello_q[$];
   logic [7:0]  ext_q[$];
   logic [15:0] hello_len;

   tls_server_hello_key_share_parser_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   tlsshp_result_checker u_chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_data        (rsp_data),
      .error_count     (error_count),
      .results_pending (results_pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin : result_pacing
      logic hold_seen;
      hold_seen = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic [15:0] len, input logic eom);
      req_type item;
      item.data_byte      = b;
      item.total_length   = len;
      item.end_of_message = eom;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_hello();
      foreach (hello_q[i]) send_byte(hello_q[i], hello_len, i == hello_q.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_pending != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic add_bytes(input int n);
      repeat (n) hello_q.push_back(8'($urandom_range(255)));
   endtask

   task automatic trim_hello(input int keep);
      while (hello_q.size() > keep) hello_q.delete(hello_q.size() - 1);
   endtask

   // type, header, version, random, session id, cipher suite, compression
   task automatic open_hello(input int sid_bytes, input logic [15:0] suite_val);
      hello_q.delete();
      ext_q.delete();
      hello_q.push_back(MSG_SERVER_HELLO);
      add_bytes(3);
      hello_q.push_back(8'h03);
      hello_q.push_back(8'h03);
      add_bytes(32);
      hello_q.push_back(8'(sid_bytes));
      add_bytes(sid_bytes);
      hello_q.push_back(suite_val[15:8]);
      hello_q.push_back(suite_val[7:0]);
      hello_q.push_back(8'h00);
   endtask

   task automatic add_ext(input logic [15:0] kind, input int body_len);
      ext_q.push_back(kind[15:8]);
      ext_q.push_back(kind[7:0]);
      ext_q.push_back(8'(body_len >> 8));
      ext_q.push_back(8'(body_len));
      repeat (body_len) ext_q.push_back(8'($urandom_range(255)));
   endtask

   // key share extension: group, declared key length, key bytes, trailing padding
   task automatic add_share(input logic [15:0] grp, input logic [15:0] klen,
                            input int key_bytes, input int pad);
      int body;
      body = 4 + key_bytes + pad;
      ext_q.push_back(EXT_KEY_SHARE[15:8]);
      ext_q.push_back(EXT_KEY_SHARE[7:0]);
      ext_q.push_back(8'(body >> 8));
      ext_q.push_back(8'(body));
      ext_q.push_back(grp[15:8]);
      ext_q.push_back(grp[7:0]);
      ext_q.push_back(klen[15:8]);
      ext_q.push_back(klen[7:0]);
      repeat (key_bytes + pad) ext_q.push_back(8'($urandom_range(255)));
   endtask

   // extensions length field, optionally skewed, then the extensions themselves
   task automatic close_hello(input int ext_skew);
      logic [15:0] tot;
      tot = 16'(int'(ext_q.size()) + ext_skew);
      hello_q.push_back(tot[15:8]);
      hello_q.push_back(tot[7:0]);
      foreach (ext_q[i]) hello_q.push_back(ext_q[i]);
      hello_len = 16'(hello_q.size());
   endtask

   task automatic random_hello();
      int sid;
      sid = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(32);
      open_hello(sid, 16'($urandom));
      repeat ($urandom_range(4)) begin
         case ($urandom_range(9))
            0, 1, 2, 3: add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
            4: add_share(GROUP_X25519, 16'($urandom_range(64)), 32, $urandom_range(4));
            5: add_share(($urandom_range(1) == 0) ? 16'h0017 : 16'($urandom),
                         SHARE_KEY_LEN, 32, $urandom_range(4));
            6: add_share(GROUP_X25519, SHARE_KEY_LEN, $urandom_range(31), 0);
            7: add_ext(($urandom_range(1) == 0) ? 16'h002b : 16'($urandom),
                       $urandom_range(12));
            8: add_ext(16'h0029, $urandom_range(12));
            default: add_ext(EXT_KEY_SHARE, $urandom_range(3));
         endcase
      end
      close_hello(($urandom_range(4) == 0) ? int'($urandom_range(48)) - 8 : 0);
      // a quarter of the messages are damaged in some way
      if ($urandom_range(3) == 0) begin
         case ($urandom_range(5))
            0: hello_q[0] = hello_q[0] ^ 8'($urandom_range(1, 255));
            1: hello_len = 16'($urandom_range(39));
            2: trim_hello($urandom_range(1, hello_q.size() - 1));
            3: add_bytes($urandom_range(1, 6));
            4: hello_len = hello_len + 16'($urandom_range(1, 20));
            default: begin
               hello_q.delete();
               add_bytes($urandom_range(1, 60));
               if ($urandom_range(1) == 0) hello_q[0] = MSG_SERVER_HELLO;
               hello_len = 16'($urandom_range(80));
            end
         endcase
      end
   endtask

   initial begin : stimulus
      int phase_no;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // plain hello with one x25519 share
      open_hello(0, 16'h1301);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      send_hello();

      // full session id, other groups and extensions around a padded share
      open_hello(32, 16'h1302);
      add_ext(16'h002b, 2);
      add_share(16'h0017, 16'd65, 65, 0);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 4);
      add_ext(16'h0000, 0);
      close_hello(0);
      send_hello();

      // two good shares, the later key wins
      open_hello(255, 16'hFFFF);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      send_hello();

      // declared key length wrong, then a share body too short
      open_hello(1, 16'h0000);
      add_share(GROUP_X25519, 16'd31, 32, 0);
      close_hello(0);
      send_hello();
      open_hello(0, 16'h1301);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 31, 0);
      close_hello(0);
      send_hello();

      // wrong message type
      open_hello(0, 16'h1301);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      hello_q[0] = 8'h01;
      send_hello();

      // length under the minimum, then length zero
      open_hello(0, 16'h1301);
      close_hello(0);
      hello_len = 16'd39;
      send_hello();
      hello_len = 16'd0;
      send_hello();

      // end mark before the length is reached, key already captured
      open_hello(0, 16'h1303);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      hello_len = hello_len + 16'd10;
      send_hello();

      // cut off just after and just before the compression byte
      open_hello(0, 16'h1304);
      close_hello(0);
      trim_hello(42);
      hello_len = 16'd42;
      send_hello();
      trim_hello(41);
      hello_len = 16'd41;
      send_hello();

      // trailing bytes past the length are ignored
      open_hello(3, 16'h1305);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      add_bytes(5);
      send_hello();

      // second share overruns the shortened extension block, first key stands
      open_hello(0, 16'h1301);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      add_ext(16'h0015, 10);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(-30);
      send_hello();

      // extension block length far beyond the message, capped
      open_hello(0, 16'h1302);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(500);
      send_hello();

      // result side held off while messages keep coming: input must back up
      hold_toggle <= ~hold_toggle;
      repeat (3) begin
         open_hello($urandom_range(8), 16'h1301);
         add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
         close_hello(0);
         send_hello();
      end
      wait_drained();

      // maximum length, more bytes than that: position counter must saturate
      open_hello(0, 16'h1303);
      add_ext(16'h0015, 65447);
      add_share(GROUP_X25519, SHARE_KEY_LEN, 32, 0);
      close_hello(0);
      add_bytes(65);
      send_hello();

      for (phase_no = 0; phase_no < 4; phase_no++) begin
         case (phase_no)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 47; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 47; end
            default: begin send_idle_pct <= 34; recv_stall_pct <= 34; end
         endcase
         repeat (PER_PHASE) begin
            random_hello();
            send_hello();
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (error_count == 0 && results_pending == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
